/* rtl/core/pfe_pkg.sv */
// Shared types, constants and small helper functions for the Playfair encryptor.
// No dependencies; used by the front end, queue, back end, top level and testbench.
package pfe_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    typedef logic [4:0] t_code;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_row;
    typedef logic [7:0] t_char;
    typedef logic [2:0] t_cmd;
    typedef logic [1:0] t_op;

    localparam t_code CODE_I = 5'd8;
    localparam t_code CODE_J = 5'd9;
    localparam t_code CODE_Q = 5'd16;
    localparam t_code CODE_Z = 5'd25;

    localparam t_char CHAR_A     = 8'h41;
    localparam t_char CHAR_Z     = 8'h5A;
    localparam t_char CHAR_SPACE = 8'h20;

    localparam t_cmd CMD_CLEAR      = 3'd0;
    localparam t_cmd CMD_KEY_CHAR   = 3'd1;
    localparam t_cmd CMD_KEY_FINISH = 3'd2;
    localparam t_cmd CMD_MSG_CHAR   = 3'd3;
    localparam t_cmd CMD_MSG_END    = 3'd4;

    localparam t_op OP_CLEAR  = 2'd0;
    localparam t_op OP_KEY    = 2'd1;
    localparam t_op OP_FINISH = 2'd2;
    localparam t_op OP_PAIR   = 2'd3;

    typedef struct packed {
        t_op   op;
        t_code a;
        t_code b;
        logic  space;
    } t_job;

    function automatic t_row row_of(t_cell c);
        t_row r;
        if (c >= t_cell'(4 * SIDE)) begin
            r = 3'd4;
        end else if (c >= t_cell'(3 * SIDE)) begin
            r = 3'd3;
        end else if (c >= t_cell'(2 * SIDE)) begin
            r = 3'd2;
        end else if (c >= t_cell'(SIDE)) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic t_row col_of(t_cell c, t_row r);
        t_cell base;
        base = t_cell'({r, 2'b00}) + t_cell'(r);
        return t_row'(c - base);
    endfunction

    function automatic t_row wrap_inc(t_row x);
        return (x == t_row'(SIDE - 1)) ? '0 : t_row'(x + 3'd1);
    endfunction

    function automatic t_cell cell_at(t_row r, t_row k);
        return t_cell'({r, 2'b00}) + t_cell'(r) + t_cell'(k);
    endfunction

    function automatic t_char letter_char(t_code v);
        return (v < t_code'(LETTERS)) ? t_char'(CHAR_A + {3'b000, v}) : CHAR_A;
    endfunction

endpackage

/* rtl/core/pfe_cmd_if.sv */
// Command channel interface of the Playfair encryptor (valid/ready + payload).
// Depends on nothing.
interface pfe_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] in_char;

    modport source (output valid, output command, output in_char, input ready);
    modport sink   (input valid, input command, input in_char, output ready);
endinterface

/* rtl/core/pfe_char_if.sv */
// Ciphertext character channel interface of the Playfair encryptor.
// Depends on nothing.
interface pfe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

/* rtl/core/pfe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pfe_front.sv */
// Front end: accepts command transactions, filters characters, inserts fillers
// and forms letter pairs. Emits jobs for the back end. Uses pfe_pkg, pfe_cmd_if.
module pfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pfe_cmd_if.sink       i_cmd,
    input  logic          i_full,
    output logic          o_push,
    output pfe_pkg::t_job o_job
);

    logic           r_pend_valid, n_pend_valid;
    logic           r_prev_valid, n_prev_valid;
    logic           r_emitted, n_emitted;
    pfe_pkg::t_code r_pend, n_pend;
    pfe_pkg::t_code r_prev, n_prev;

    logic           accept;
    logic           upper;
    pfe_pkg::t_code code;
    logic           need_fill;
    pfe_pkg::t_code fill_code;
    pfe_pkg::t_code end_code;

    assign i_cmd.ready = !i_full;
    assign accept      = i_cmd.valid && !i_full;
    assign upper       = (i_cmd.in_char >= pfe_pkg::CHAR_A) && (i_cmd.in_char <= pfe_pkg::CHAR_Z);
    assign code        = pfe_pkg::t_code'(i_cmd.in_char - pfe_pkg::CHAR_A);
    assign need_fill   = r_prev_valid &&
                         ((code == r_prev) ||
                          (code == pfe_pkg::CODE_I && r_prev == pfe_pkg::CODE_J) ||
                          (code == pfe_pkg::CODE_J && r_prev == pfe_pkg::CODE_I));
    assign fill_code   = (code == pfe_pkg::CODE_Q) ? pfe_pkg::CODE_Z : pfe_pkg::CODE_Q;
    assign end_code    = (r_prev == pfe_pkg::CODE_Q) ? pfe_pkg::CODE_Z : pfe_pkg::CODE_Q;

    always_comb begin
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_emitted    = r_emitted;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.space  = r_emitted;
        if (accept) begin
            unique case (i_cmd.command)
                pfe_pkg::CMD_CLEAR: begin
                    o_push   = 1'b1;
                    o_job.op = pfe_pkg::OP_CLEAR;
                end
                pfe_pkg::CMD_KEY_CHAR: begin
                    if (upper) begin
                        o_push   = 1'b1;
                        o_job.op = pfe_pkg::OP_KEY;
                        o_job.a  = code;
                    end
                end
                pfe_pkg::CMD_KEY_FINISH: begin
                    o_push   = 1'b1;
                    o_job.op = pfe_pkg::OP_FINISH;
                end
                pfe_pkg::CMD_MSG_CHAR: begin
                    if (upper) begin
                        o_job.op = pfe_pkg::OP_PAIR;
                        if (need_fill && r_pend_valid) begin
                            o_push       = 1'b1;
                            o_job.a      = r_pend;
                            o_job.b      = fill_code;
                            n_pend       = code;
                            n_pend_valid = 1'b1;
                        end else if (need_fill || r_pend_valid) begin
                            o_push       = 1'b1;
                            o_job.a      = need_fill ? fill_code : r_pend;
                            o_job.b      = code;
                            n_pend_valid = 1'b0;
                        end else begin
                            n_pend       = code;
                            n_pend_valid = 1'b1;
                        end
                        n_prev       = code;
                        n_prev_valid = 1'b1;
                        if (o_push) begin
                            n_emitted = 1'b1;
                        end
                    end
                end
                pfe_pkg::CMD_MSG_END: begin
                    if (r_pend_valid) begin
                        o_push   = 1'b1;
                        o_job.op = pfe_pkg::OP_PAIR;
                        o_job.a  = r_pend;
                        o_job.b  = end_code;
                    end
                    n_pend_valid = 1'b0;
                    n_prev_valid = 1'b0;
                    n_emitted    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_prev_valid <= 1'b0;
            r_emitted    <= 1'b0;
            r_pend       <= '0;
            r_prev       <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_prev_valid <= n_prev_valid;
            r_emitted    <= n_emitted;
            r_pend       <= n_pend;
            r_prev       <= n_prev;
        end
    end

    a_pend_has_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_prev_valid)
        else $error("pending letter without previous letter");

endmodule

/* rtl/core/pfe_queue.sv */
// Short job queue between front and back end, kept in flip-flops.
// Uses pfe_pkg.
module pfe_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfe_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output pfe_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pfe_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = CW'(r_count + 1'b1);
            2'b01:   n_count = CW'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/core/pfe_back.sv */
// Back end: builds the key square in two RAMs, runs key finish, encrypts pairs
// and drives the character channel. Uses pfe_pkg, pfe_char_if, pfe_ram.
module pfe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pfe_pkg::t_job i_job,
    output logic          o_pop,
    pfe_char_if.source    o_char
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FILL  = 4'd1;
    localparam logic [3:0] S_FIXJ  = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_ADDR  = 4'd5;
    localparam logic [3:0] S_SQ0   = 4'd6;
    localparam logic [3:0] S_SQ1   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    localparam logic [1:0] EMIT_SPACE = 2'd0;
    localparam logic [1:0] EMIT_FIRST = 2'd1;
    localparam logic [1:0] EMIT_LAST  = 2'd2;

    logic [3:0]                   r_state, n_state;
    logic [pfe_pkg::LETTERS-1:0]  r_placed, n_placed;
    pfe_pkg::t_cell               r_fill, n_fill;
    pfe_pkg::t_cell               r_ij_cell, n_ij_cell;
    logic                         r_jflag, n_jflag;
    pfe_pkg::t_code               r_idx, n_idx;
    pfe_pkg::t_job                r_job, n_job;
    pfe_pkg::t_row                r_row0, n_row0, r_col0, n_col0;
    pfe_pkg::t_row                r_row1, n_row1, r_col1, n_col1;
    pfe_pkg::t_cell               r_addr1, n_addr1;
    pfe_pkg::t_char               r_ch0, n_ch0, r_ch1, n_ch1;
    logic [1:0]                   r_emit, n_emit;
    logic                         r_ov, n_ov;
    pfe_pkg::t_char               r_odata, n_odata;
    logic                         r_olast, n_olast;

    logic           p_en;
    pfe_pkg::t_code p_code, p_mate;
    logic           p_ij;

    logic           cell_we;
    pfe_pkg::t_code cell_waddr, cell_raddr;
    pfe_pkg::t_cell cell_wdata, cell_rdata;
    logic           sq_we;
    pfe_pkg::t_cell sq_waddr, sq_raddr;
    pfe_pkg::t_code sq_wdata, sq_rdata;

    pfe_pkg::t_code rd_code;
    pfe_pkg::t_cell rd_cell;
    pfe_pkg::t_row  rd_row;
    pfe_pkg::t_cell addr0, addr1;
    logic           out_load;

    pfe_ram #(.WIDTH(5), .DEPTH(pfe_pkg::LETTERS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    pfe_ram #(.WIDTH(5), .DEPTH(pfe_pkg::CELLS)) u_square_ram (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_waddr),
        .i_wdata (sq_wdata),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    // unplaced letters encrypt as cell zero
    assign rd_code  = (r_state == S_RDA) ? r_job.a : r_job.b;
    assign rd_cell  = r_placed[rd_code] ? cell_rdata : '0;
    assign rd_row   = pfe_pkg::row_of(rd_cell);
    assign out_load = (r_state == S_EMIT) && (!r_ov || o_char.ready);

    assign p_mate = (p_code == pfe_pkg::CODE_I) ? pfe_pkg::CODE_J : pfe_pkg::CODE_I;
    assign p_ij   = (p_code == pfe_pkg::CODE_I) || (p_code == pfe_pkg::CODE_J);

    always_comb begin
        if (r_row0 == r_row1) begin
            addr0 = pfe_pkg::cell_at(r_row0, pfe_pkg::wrap_inc(r_col0));
            addr1 = pfe_pkg::cell_at(r_row1, pfe_pkg::wrap_inc(r_col1));
        end else if (r_col0 == r_col1) begin
            addr0 = pfe_pkg::cell_at(pfe_pkg::wrap_inc(r_row0), r_col0);
            addr1 = pfe_pkg::cell_at(pfe_pkg::wrap_inc(r_row1), r_col1);
        end else begin
            addr0 = pfe_pkg::cell_at(r_row0, r_col1);
            addr1 = pfe_pkg::cell_at(r_row1, r_col0);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_placed  = r_placed;
        n_fill    = r_fill;
        n_ij_cell = r_ij_cell;
        n_jflag   = r_jflag;
        n_idx     = r_idx;
        n_job     = r_job;
        n_row0    = r_row0;
        n_col0    = r_col0;
        n_row1    = r_row1;
        n_col1    = r_col1;
        n_addr1   = r_addr1;
        n_ch0     = r_ch0;
        n_ch1     = r_ch1;
        n_emit    = r_emit;
        n_ov      = r_ov;
        n_odata   = r_odata;
        n_olast   = r_olast;
        o_pop     = 1'b0;
        p_en      = 1'b0;
        p_code    = r_idx;
        cell_we   = 1'b0;
        cell_waddr = p_code;
        cell_wdata = r_fill;
        cell_raddr = i_job.a;
        sq_we     = 1'b0;
        sq_waddr  = r_fill;
        sq_wdata  = p_code;
        sq_raddr  = addr0;

        if (r_ov && o_char.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    unique case (i_job.op)
                        pfe_pkg::OP_CLEAR: begin
                            n_placed = '0;
                            n_fill   = '0;
                            n_jflag  = 1'b0;
                        end
                        pfe_pkg::OP_KEY: begin
                            p_en   = 1'b1;
                            p_code = i_job.a;
                        end
                        pfe_pkg::OP_FINISH: begin
                            n_idx   = '0;
                            n_state = S_FILL;
                        end
                        pfe_pkg::OP_PAIR: begin
                            n_state = S_RDA;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                p_en   = 1'b1;
                p_code = r_idx;
                if (r_idx == pfe_pkg::t_code'(pfe_pkg::LETTERS - 1)) begin
                    n_state = S_FIXJ;
                end else begin
                    n_idx = pfe_pkg::t_code'(r_idx + 1'b1);
                end
            end
            S_FIXJ: begin
                // shared I/J cell holding J now prints as I
                if (r_jflag) begin
                    sq_we    = 1'b1;
                    sq_waddr = r_ij_cell;
                    sq_wdata = pfe_pkg::CODE_I;
                    n_jflag  = 1'b0;
                end
                n_state = S_IDLE;
            end
            S_RDA: begin
                n_row0     = rd_row;
                n_col0     = pfe_pkg::col_of(rd_cell, rd_row);
                cell_raddr = r_job.b;
                n_state    = S_RDB;
            end
            S_RDB: begin
                n_row1  = rd_row;
                n_col1  = pfe_pkg::col_of(rd_cell, rd_row);
                n_state = S_ADDR;
            end
            S_ADDR: begin
                sq_raddr = addr0;
                n_addr1  = addr1;
                n_state  = S_SQ0;
            end
            S_SQ0: begin
                n_ch0    = pfe_pkg::letter_char(sq_rdata);
                sq_raddr = r_addr1;
                n_state  = S_SQ1;
            end
            S_SQ1: begin
                n_ch1   = pfe_pkg::letter_char(sq_rdata);
                n_emit  = r_job.space ? EMIT_SPACE : EMIT_FIRST;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_ov = 1'b1;
                    unique case (r_emit)
                        EMIT_SPACE: begin
                            n_odata = pfe_pkg::CHAR_SPACE;
                            n_olast = 1'b0;
                            n_emit  = EMIT_FIRST;
                        end
                        EMIT_FIRST: begin
                            n_odata = r_ch0;
                            n_olast = 1'b0;
                            n_emit  = EMIT_LAST;
                        end
                        default: begin
                            n_odata = r_ch1;
                            n_olast = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (p_en && !r_placed[p_code]) begin
            cell_waddr = p_code;
            if (p_ij && r_placed[p_mate]) begin
                cell_we          = 1'b1;
                cell_wdata       = r_ij_cell;
                n_placed[p_code] = 1'b1;
            end else if (r_fill < pfe_pkg::t_cell'(pfe_pkg::CELLS)) begin
                sq_we            = 1'b1;
                sq_waddr         = r_fill;
                sq_wdata         = p_code;
                cell_we          = 1'b1;
                cell_wdata       = r_fill;
                n_placed[p_code] = 1'b1;
                n_fill           = pfe_pkg::t_cell'(r_fill + 1'b1);
                if (p_ij) begin
                    n_ij_cell = r_fill;
                end
                if (p_code == pfe_pkg::CODE_J) begin
                    n_jflag = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_placed <= '0;
            r_fill   <= '0;
            r_jflag  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_placed <= n_placed;
            r_fill   <= n_fill;
            r_jflag  <= n_jflag;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ij_cell <= n_ij_cell;
        r_idx     <= n_idx;
        r_job     <= n_job;
        r_row0    <= n_row0;
        r_col0    <= n_col0;
        r_row1    <= n_row1;
        r_col1    <= n_col1;
        r_addr1   <= n_addr1;
        r_ch0     <= n_ch0;
        r_ch1     <= n_ch1;
        r_emit    <= n_emit;
        r_odata   <= n_odata;
        r_olast   <= n_olast;
    end

    assign o_char.valid    = r_ov;
    assign o_char.out_char = r_odata;
    assign o_char.last     = r_olast;

    a_square_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIXJ) |-> (r_fill == pfe_pkg::t_cell'(pfe_pkg::CELLS)))
        else $error("key finish left free cells");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_placed) ==
            int'(r_fill) + int'(r_placed[pfe_pkg::CODE_I] & r_placed[pfe_pkg::CODE_J]))
        else $error("placed letters disagree with fill position");

    a_jflag_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jflag |-> (r_placed[pfe_pkg::CODE_J] && !$past(r_state == S_FIXJ)))
        else $error("J cell marked without J placed");

endmodule

/* rtl/core/playfair_digraph_encryptor_top.sv */
// Playfair digraph encryptor top level: front end, job queue and back end.
// Uses pfe_pkg, pfe_cmd_if, pfe_char_if, pfe_front, pfe_queue, pfe_back.
//
// Usage:
//   i_cmd carries one command transaction (command, in_char) per valid/ready
//   handshake: clear key, key character, key finish, message character,
//   message end. o_char returns ciphertext characters; last marks the final
//   character caused by one command, at most three (space, letter, letter).
//   The front end takes a transaction every cycle while the job queue
//   (QUEUE_DEPTH entries) has room; ignored characters never enter the queue.
//   Back end per job: clear key and key character take effect as it is popped;
//   key finish visits each letter (S_FILL), then does the I/J fix-up (S_FIXJ);
//   a pair reads the letter-to-cell RAM for both letters (S_RDA, S_RDB), forms
//   the cipher cells (S_ADDR), reads the square RAM (S_SQ0, S_SQ1) and sends
//   its characters one by one (S_EMIT) through the output register.
//   When the receiver stalls, the output register holds its character, the
//   back end waits, the queue fills and i_cmd.ready drops.
//   Synchronous reset empties the queue, clears the key square occupancy and
//   the message state; the square RAMs are not cleared.
module playfair_digraph_encryptor_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfe_cmd_if.sink    i_cmd,
    pfe_char_if.source o_char
);

    logic          push;
    pfe_pkg::t_job push_job;
    logic          full;
    logic          q_valid;
    logic          pop;
    pfe_pkg::t_job q_job;

    pfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    pfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (q_job)
    );

    pfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_char  (o_char)
    );

endmodule

/* bench/playfair_digraph_encryptor_top_tb.sv */
// Testbench for playfair_digraph_encryptor_top: drives key and message command transactions,
// predicts the ciphertext stream in a scoreboard class and checks every character.
// Depends on pfe_pkg, pfe_cmd_if, pfe_char_if and the encryptor RTL.
`timescale 1ns / 100ps

module playfair_digraph_encryptor_top_tb;
    import pfe_pkg::*;

    localparam int   CYCLE_LIMIT      = 400000;
    localparam int   ITEM_TARGET      = 110;
    localparam int   TAIL_ITEMS       = 20;
    localparam int   SETTLE_CYCLES    = 64;
    localparam int   HOLD_CYCLES      = 400;
    localparam int   MAX_REPORTS      = 10;
    localparam t_cmd CMD_UNUSED_FIRST = 3'd5;
    localparam t_cmd CMD_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_cipher_char;

    function automatic bit is_letter(t_char ch);
        return ch >= CHAR_A && ch <= CHAR_Z;
    endfunction

    function automatic t_char random_letter();
        return t_char'(CHAR_A + $urandom_range(0, LETTERS - 1));
    endfunction

    class cipher_scoreboard;
        t_cell        letter_cell   [LETTERS];
        bit           letter_placed [LETTERS];
        t_code        square_letter [CELLS];
        t_cell        fill_pos;
        t_code        pending_letter;
        bit           pending_valid;
        t_code        prev_letter;
        bit           prev_valid;
        bit           pair_emitted;
        t_cipher_char expected_chars [$];
        t_cipher_char step_chars [$];
        int           mismatches;

        function new();
            foreach (letter_cell[i]) begin
                letter_cell[i]   = '0;
                letter_placed[i] = 1'b0;
            end
            foreach (square_letter[i]) begin
                square_letter[i] = '0;
            end
            fill_pos       = '0;
            pending_letter = '0;
            pending_valid  = 1'b0;
            prev_letter    = '0;
            prev_valid     = 1'b0;
            pair_emitted   = 1'b0;
            mismatches     = 0;
        endfunction

        function void place_letter(t_code code);
            t_code mate;
            if (letter_placed[code]) begin
                return;
            end
            if (code == CODE_I || code == CODE_J) begin
                mate = (code == CODE_I) ? CODE_J : CODE_I;
                if (letter_placed[mate]) begin
                    letter_cell[code]   = letter_cell[mate];
                    letter_placed[code] = 1'b1;
                    return;
                end
            end
            if (fill_pos >= t_cell'(CELLS)) begin
                return;
            end
            square_letter[fill_pos] = code;
            letter_cell[code]       = fill_pos;
            letter_placed[code]     = 1'b1;
            fill_pos++;
        endfunction

        function t_cell cell_of(t_code code);
            return letter_placed[code] ? letter_cell[code] : t_cell'(0);
        endfunction

        function t_char square_char(int row, int col);
            return t_char'(CHAR_A + square_letter[(row % SIDE) * SIDE + col % SIDE]);
        endfunction

        function void emit(t_char ch);
            step_chars.push_back('{ch: ch, last: 1'b0});
        endfunction

        function void encrypt_pair(t_code a, t_code b);
            int r0, k0, r1, k1;
            r0 = cell_of(a) / SIDE;
            k0 = cell_of(a) % SIDE;
            r1 = cell_of(b) / SIDE;
            k1 = cell_of(b) % SIDE;
            if (pair_emitted) begin
                emit(CHAR_SPACE);
            end
            if (r0 == r1) begin
                emit(square_char(r0, k0 + 1));
                emit(square_char(r1, k1 + 1));
            end else if (k0 == k1) begin
                emit(square_char(r0 + 1, k0));
                emit(square_char(r1 + 1, k1));
            end else begin
                emit(square_char(r0, k1));
                emit(square_char(r1, k0));
            end
            pair_emitted = 1'b1;
        endfunction

        function void push_letter(t_code code);
            if (!pending_valid) begin
                pending_letter = code;
                pending_valid  = 1'b1;
            end else begin
                encrypt_pair(pending_letter, code);
                pending_valid = 1'b0;
            end
        endfunction

        function void note_command(t_cmd cmd, t_char ch);
            t_code        code;
            bit           upper;
            int           i;
            t_cipher_char entry;
            upper = is_letter(ch);
            code  = upper ? t_code'(ch - CHAR_A) : '0;
            step_chars.delete();
            case (cmd)
                CMD_CLEAR: begin
                    foreach (letter_placed[j]) begin
                        letter_placed[j] = 1'b0;
                    end
                    fill_pos = '0;
                end
                CMD_KEY_CHAR: begin
                    if (upper) begin
                        place_letter(code);
                    end
                end
                CMD_KEY_FINISH: begin
                    for (i = 0; i < LETTERS; i++) begin
                        place_letter(t_code'(i));
                    end
                    for (i = 0; i < CELLS; i++) begin
                        if (square_letter[i] == CODE_J) begin
                            square_letter[i] = CODE_I;
                            break;
                        end
                    end
                end
                CMD_MSG_CHAR: begin
                    if (upper) begin
                        if (prev_valid && (code == prev_letter ||
                                (code == CODE_I && prev_letter == CODE_J) ||
                                (code == CODE_J && prev_letter == CODE_I))) begin
                            push_letter(code == CODE_Q ? CODE_Z : CODE_Q);
                        end
                        push_letter(code);
                        prev_letter = code;
                        prev_valid  = 1'b1;
                    end
                end
                CMD_MSG_END: begin
                    if (pending_valid) begin
                        push_letter(prev_letter == CODE_Q ? CODE_Z : CODE_Q);
                    end
                    pending_valid = 1'b0;
                    prev_valid    = 1'b0;
                    pair_emitted  = 1'b0;
                end
                default: begin
                end
            endcase
            foreach (step_chars[j]) begin
                entry      = step_chars[j];
                entry.last = (j == step_chars.size() - 1);
                expected_chars.push_back(entry);
            end
        endfunction

        function void report(string what, t_cipher_char want, t_char ch, logic last);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s: expected char 8'h%02h last %0b, got char 8'h%02h last %0b",
                         $time, what, want.ch, want.last, ch, last);
            end
        endfunction

        function void check_char(t_char ch, logic last);
            t_cipher_char want;
            if (expected_chars.size() == 0) begin
                want = '0;
                report("unexpected character", want, ch, last);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last) begin
                report("character mismatch", want, ch, last);
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfe_cmd_if  cmd_bus ();
    pfe_char_if char_bus ();

    cipher_scoreboard scoreboard = new();

    int cycle_count  = 0;
    int items_sent   = 0;
    int rx_hold_left = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit quiet_tail   = 1'b0;

    playfair_digraph_encryptor_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_char  (char_bus)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && char_bus.valid && char_bus.ready) begin
            scoreboard.check_char(char_bus.out_char, char_bus.last);
        end
    end

    initial begin : rx_ready_gen
        int idle_left;
        idle_left      = 0;
        char_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                char_bus.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                char_bus.ready <= 1'b0;
            end else if (!quiet_tail && rx_idle_on && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(0, 14);
                char_bus.ready <= 1'b0;
            end else begin
                char_bus.ready <= 1'b1;
            end
            if ($urandom_range(0, 99) == 0) begin
                rx_idle_on = !rx_idle_on;
            end
        end
    end

    // Called just after a falling edge; returns just after the falling edge that follows acceptance.
    task automatic send_command(t_cmd cmd, t_char ch);
        if (tx_idle_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= cmd;
        cmd_bus.in_char <= ch;
        do @(posedge i_clk); while (!cmd_bus.ready);
        scoreboard.note_command(cmd, ch);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(t_cmd cmd, string text);
        int k;
        for (k = 0; k < text.len(); k++) begin
            send_command(cmd, t_char'(text[k]));
        end
    endtask

    task automatic send_key(int len, bit finish);
        int k;
        send_command(CMD_CLEAR, t_char'($urandom_range(0, 255)));
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_command(CMD_KEY_CHAR, t_char'($urandom_range(0, 255)));
            end else begin
                send_command(CMD_KEY_CHAR, random_letter());
            end
        end
        if (finish) begin
            send_command(CMD_KEY_FINISH, t_char'($urandom_range(0, 255)));
        end
    endtask

    // Doubled letters and I/J neighbors are made frequent to hit the filler logic.
    task automatic send_message(int letters, bit close);
        t_char prev_ch;
        t_char ch;
        int    k;
        prev_ch = random_letter();
        for (k = 0; k < letters; k++) begin
            case ($urandom_range(0, 9))
                0, 1: ch = prev_ch;
                2: ch = (prev_ch == t_char'(CHAR_A + CODE_I)) ? t_char'(CHAR_A + CODE_J)
                                                             : t_char'(CHAR_A + CODE_I);
                3: ch = t_char'($urandom_range(0, 255));
                default: ch = random_letter();
            endcase
            send_command(CMD_MSG_CHAR, ch);
            if (is_letter(ch)) begin
                prev_ch = ch;
            end
        end
        if (close) begin
            send_command(CMD_MSG_END, t_char'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_for_results();
        cmd_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (scoreboard.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        bit held;
        bit paused;
        held            = 1'b0;
        paused          = 1'b0;
        i_rst_n         = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = CMD_CLEAR;
        cmd_bus.in_char = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // J placed before I, so I shares J's cell, which finish then prints as I.
        send_command(CMD_KEY_CHAR, 8'hFF);
        send_text(CMD_KEY_CHAR, "JYI");
        send_command(CMD_KEY_FINISH, 8'h00);
        send_command(CMD_KEY_CHAR, "B");
        send_command(CMD_MSG_END, 8'h7F);
        send_text(CMD_MSG_CHAR, "ALLQQIJ");
        send_command(CMD_MSG_CHAR, 8'h00);
        send_command(CMD_MSG_CHAR, "Z");
        send_command(CMD_MSG_END, 8'h00);
        send_command(CMD_MSG_CHAR, "Q");
        send_command(CMD_MSG_END, 8'hFF);
        send_command(CMD_UNUSED_LAST, "A");
        send_command(CMD_UNUSED_FIRST, 8'hAA);
        // Partial key: unplaced letters map to cell zero, old cells read as stored.
        send_command(CMD_CLEAR, 8'h55);
        send_command(CMD_KEY_CHAR, "X");
        send_text(CMD_MSG_CHAR, "MN");
        send_command(CMD_MSG_END, 8'h00);
        send_command(CMD_KEY_FINISH, 8'hFF);

        while (items_sent < ITEM_TARGET) begin
            tx_idle_on = $urandom_range(0, 3) != 0;
            quiet_tail = items_sent >= ITEM_TARGET - TAIL_ITEMS;
            if (!held && items_sent >= 40) begin
                held         = 1'b1;
                rx_hold_left = HOLD_CYCLES;
                send_message(24, 1'b1);
            end else if (!paused && items_sent >= 70) begin
                paused = 1'b1;
                wait_for_results();
            end else begin
                case ($urandom_range(0, 9))
                    0: send_key($urandom_range(2, 10), $urandom_range(0, 3) != 0);
                    1: send_command(t_cmd'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                                    t_char'($urandom_range(0, 255)));
                    default: send_message($urandom_range(1, 12), $urandom_range(0, 7) != 0);
                endcase
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (scoreboard.pending() == 0 && scoreboard.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            if (scoreboard.pending() != 0) begin
                $display("%0d expected characters never arrived", scoreboard.pending());
            end
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/pfe_pkg.sv
rtl/core/pfe_cmd_if.sv
rtl/core/pfe_char_if.sv
rtl/core/pfe_ram.sv
rtl/core/pfe_front.sv
rtl/core/pfe_queue.sv
rtl/core/pfe_back.sv
rtl/core/playfair_digraph_encryptor_top.sv
bench/playfair_digraph_encryptor_top_tb.sv
